[rtl/hng_pkg.sv]
// hamming number generator: shared constants, state encoding and control structs
// no dependencies; imported by hng_ifs, hng_ctrl, hng_dp and the top level
package hng_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = 13;
    localparam int VAL_W       = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_READ,
        S_MUL,
        S_PICK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic init;
        logic mul;
        logic pick;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic bad;
        logic fill_reached;
    } dp_status_t;

endpackage

[rtl/hng_ifs.sv]
// hamming number generator: request and response channel interfaces
// depends on hng_pkg for field widths
interface hng_req_if
    import hng_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] requested_index;

    modport source (output valid, output requested_index, input ready);
    modport sink   (input valid, input requested_index, output ready);
endinterface

interface hng_rsp_if
    import hng_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] hamming_value;
    logic             index_bad;

    modport source (output valid, output hamming_value, output index_bad, input ready);
    modport sink   (input valid, input hamming_value, input index_bad, output ready);
endinterface

[rtl/hng_ram.sv]
// hamming number generator: generic single write port ram with registered read
// no dependencies
module hng_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/hng_ctrl.sv]
// hamming number generator: sequencing state machine and output slot control
// depends on hng_pkg
module hng_ctrl
    import hng_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                state_next = status.bad ? S_DONE : S_READ;
            end
            S_READ:
            begin
                state_next = status.fill_reached ? S_DONE : S_MUL;
            end
            S_MUL:
            begin
                state_next = S_PICK;
            end
            S_PICK:
            begin
                state_next = S_READ;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_INIT:
            begin
                cmd.init = 1'b1;
            end
            S_READ:
            begin
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
            end
            S_PICK:
            begin
                cmd.pick = 1'b1;
            end
            S_DONE:
            begin
                cmd.load_out = slot_free;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("result load did not raise output valid");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

    a_bad_skips_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INIT && status.bad) |=> state_reg == S_DONE)
        else $error("rejected index entered the fill loop");

endmodule

[rtl/hng_dp.sv]
// hamming number generator: table rams, pointers, candidates and result register
// depends on hng_pkg and hng_ram
module hng_dp
    import hng_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] requested_index,
    input  dp_cmd_t          cmd,
    output dp_status_t       status,
    output logic [VAL_W-1:0] hamming_value,
    output logic             index_bad
);

    logic [CNT_W-1:0]  n_reg;
    logic              bad_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [ADDR_W-1:0] ptr_two_reg;
    logic [ADDR_W-1:0] ptr_three_reg;
    logic [ADDR_W-1:0] ptr_five_reg;
    logic [VAL_W-1:0]  cand_two_reg;
    logic [VAL_W-1:0]  cand_three_reg;
    logic [VAL_W-1:0]  cand_five_reg;
    logic [VAL_W-1:0]  least_reg;
    logic [VAL_W-1:0]  result_reg;
    logic              result_bad_reg;

    logic [VAL_W-1:0]  rd_two;
    logic [VAL_W-1:0]  rd_three;
    logic [VAL_W-1:0]  rd_five;
    logic [VAL_W-1:0]  least_comb;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [VAL_W-1:0]  ram_wdata;
    logic              index_rejected;

    assign index_rejected = (requested_index == '0)
                         || (requested_index > IDX_W'(TABLE_DEPTH));

    // least of the three candidates
    always_comb
    begin
        least_comb = cand_two_reg;
        if (cand_three_reg < least_comb)
        begin
            least_comb = cand_three_reg;
        end
        if (cand_five_reg < least_comb)
        begin
            least_comb = cand_five_reg;
        end
    end

    assign ram_we    = cmd.init || cmd.pick;
    assign ram_waddr = cmd.init ? '0 : fill_reg[ADDR_W-1:0];
    assign ram_wdata = cmd.init ? VAL_W'(1) : least_comb;

    // one copy per pointer so each gets its own read port
    hng_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_ram_two (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_two_reg),
        .rdata (rd_two)
    );

    hng_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_ram_three (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_three_reg),
        .rdata (rd_three)
    );

    hng_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_ram_five (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_five_reg),
        .rdata (rd_five)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= CNT_W'(1);
            ptr_two_reg   <= '0;
            ptr_three_reg <= '0;
            ptr_five_reg  <= '0;
        end
        else if (cmd.init)
        begin
            fill_reg      <= CNT_W'(1);
            ptr_two_reg   <= '0;
            ptr_three_reg <= '0;
            ptr_five_reg  <= '0;
        end
        else if (cmd.pick)
        begin
            fill_reg <= fill_reg + CNT_W'(1);
            if (least_comb == cand_two_reg)
            begin
                ptr_two_reg <= ptr_two_reg + ADDR_W'(1);
            end
            if (least_comb == cand_three_reg)
            begin
                ptr_three_reg <= ptr_three_reg + ADDR_W'(1);
            end
            if (least_comb == cand_five_reg)
            begin
                ptr_five_reg <= ptr_five_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            n_reg   <= CNT_W'(requested_index);
            bad_reg <= index_rejected;
        end
        if (cmd.init)
        begin
            least_reg <= VAL_W'(1);
        end
        else if (cmd.pick)
        begin
            least_reg <= least_comb;
        end
        // times 2, 3 and 5 as shift and add
        if (cmd.mul)
        begin
            cand_two_reg   <= rd_two << 1;
            cand_three_reg <= (rd_three << 1) + rd_three;
            cand_five_reg  <= (rd_five << 2) + rd_five;
        end
        if (cmd.load_out)
        begin
            result_reg     <= bad_reg ? '0 : least_reg;
            result_bad_reg <= bad_reg;
        end
    end

    assign status.bad          = bad_reg;
    assign status.fill_reached = fill_reg >= n_reg;
    assign hamming_value       = result_reg;
    assign index_bad           = result_bad_reg;

    a_pointers_behind_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W'(ptr_two_reg) < fill_reg) && (CNT_W'(ptr_three_reg) < fill_reg)
        && (CNT_W'(ptr_five_reg) < fill_reg))
        else $error("pointer reached unwritten table entry");

    a_table_increasing: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pick |-> least_comb > least_reg)
        else $error("new table entry not above previous one");

endmodule

[rtl/hamming_number_generator.sv]
// hamming number generator top level: joins the controller and the datapath
// depends on hng_pkg, hng_ifs, hng_ctrl and hng_dp
//
// usage:
//   req carries requested_index (n); rsp carries hamming_value and index_bad.
//   an item moves on either channel when valid and ready are both high.
//   each request rebuilds a scratch table of 5-smooth numbers from 1 upward
//   with the three-pointer method and answers with the nth entry.
//   n of zero or above 4096 is rejected: hamming_value 0, index_bad 1.
// sequencing:
//   one request at a time; req.ready is high only while the block is idle.
//   each new table entry takes three steps: table ram read, multiply by
//   2/3/5, then pick the least candidate and write it back.
//   a rejected index skips the table fill and goes straight to the result;
//   the block is ready for the next request in the cycle after the load.
// reset:
//   rst_n clears the sequencer and the output slot; the table needs no clear
//   since every entry is written before it is read within a request.
// stall:
//   a finished result sits in the output register; the block returns to idle
//   and takes the next request, and a second result waits until rsp.ready.
module hamming_number_generator
    import hng_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    hng_req_if.sink   req,
    hng_rsp_if.source rsp
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_ready;
    logic       out_valid;

    hng_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    hng_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .requested_index (req.requested_index),
        .cmd             (cmd),
        .status          (status),
        .hamming_value   (rsp.hamming_value),
        .index_bad       (rsp.index_bad)
    );

    assign req.ready = in_ready;
    assign rsp.valid = out_valid;

endmodule
